FILE: hw/rtl/dsbor_pkg.sv
`default_nettype none

package dsbor_pkg;

    localparam int CORE_W      = 4;
    localparam int PC_W        = 64;
    localparam int OPCODE_W    = 32;
    localparam int DSBOR_CORES = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_SPARC_DECODE_ON = 1'b0;

    // sparc v9 opcode fields
    localparam logic [1:0] OP_BRANCH   = 2'd0;
    localparam logic [1:0] OP_CALL     = 2'd1;
    localparam logic [1:0] OP_ARITH    = 2'd2;
    localparam logic [5:0] OP3_JMPL    = 6'h38;
    localparam logic [5:0] OP3_RETURN  = 6'h39;
    localparam int         ANNUL_BIT   = 29;

    // sparc v9 op2 encodings of format 2
    localparam logic [2:0] OP2_ILLTRAP = 3'd0;
    localparam logic [2:0] OP2_BPCC    = 3'd1;
    localparam logic [2:0] OP2_BICC    = 3'd2;
    localparam logic [2:0] OP2_BPR     = 3'd3;
    localparam logic [2:0] OP2_SETHI   = 3'd4;
    localparam logic [2:0] OP2_FBPFCC  = 3'd5;
    localparam logic [2:0] OP2_FBFCC   = 3'd6;
    localparam logic [2:0] OP2_RSVD    = 3'd7;

    localparam logic [PC_W-1:0] FALL_OFFSET = 64'd8;

    typedef enum logic [1:0] {
        BR_NONE   = 2'd0,
        BR_COND   = 2'd1,
        BR_UNCOND = 2'd2
    } br_type_t;

    typedef struct packed {
        br_type_t btype;
        logic     annul;
    } decode_t;

    typedef struct packed {
        br_type_t         btype;
        logic             annul;
        logic [PC_W-1:0]  addr;
    } slot_t;

    typedef struct packed {
        slot_t older;
        slot_t newer;
    } row_t;

    // input transaction payload, lowest field in the lowest bits
    typedef struct packed {
        logic                pad;
        logic                given_annul;
        logic [1:0]          given_type;
        logic [OPCODE_W-1:0] opcode;
        logic [PC_W-1:0]     pc;
        logic [CORE_W-1:0]   core;
    } item_t;

    // output transaction payload, lowest field in the lowest bits
    typedef struct packed {
        logic [6:0]        pad;
        logic [PC_W-1:0]   predict_pc;
        logic              predict_valid;
        logic [PC_W-1:0]   feedback_target;
        logic              feedback_taken;
        br_type_t          feedback_type;
        logic [PC_W-1:0]   feedback_pc;
        logic              feedback_valid;
        logic [CORE_W-1:0] core_out;
    } result_t;

    localparam int S_TDATA_W = $bits(item_t);
    localparam int M_TDATA_W = $bits(result_t);

endpackage

`default_nettype wire

FILE: hw/rtl/dsbor_decode.sv
`default_nettype none

module dsbor_decode
    import dsbor_pkg::*;
(
    input  wire logic                kind,
    input  wire logic                decode_on,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire logic [1:0]          given_type,
    input  wire logic                given_annul,
    output decode_t                  dec
);

    logic [1:0] op;
    logic [2:0] op2;
    logic [5:0] op3;

    assign op  = opcode[31:30];
    assign op2 = opcode[24:22];
    assign op3 = opcode[24:19];

    always_comb
    begin
        dec = '{btype: BR_NONE, annul: 1'b0};
        if (kind)
        begin
            case (given_type)
                BR_COND:   dec.btype = BR_COND;
                BR_UNCOND: dec.btype = BR_UNCOND;
                default:   dec.btype = BR_NONE;
            endcase
            dec.annul = given_annul;
        end
        else if (decode_on)
        begin
            case (op)
                OP_BRANCH:
                begin
                    if (op2 inside {OP2_BPCC, OP2_BICC, OP2_BPR, OP2_FBPFCC, OP2_FBFCC})
                    begin
                        dec.btype = BR_COND;
                        dec.annul = opcode[ANNUL_BIT];
                    end
                end
                OP_CALL:
                begin
                    dec.btype = BR_UNCOND;
                end
                OP_ARITH:
                begin
                    if (op3 inside {OP3_JMPL, OP3_RETURN})
                    begin
                        dec.btype = BR_UNCOND;
                    end
                end
                default:
                begin
                    dec.btype = BR_NONE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/delay_slot_branch_outcome_resolver.sv
// path: input is registered in stage 1, then in the output register driving m_tvalid
// throughput: one transaction per cycle unless m_tready stalls, set by the single
// per-core history read-modify-write (registered read, write-back forwarded to the next item)
// reset: rst_n asynchronous active low; clears all core histories through
// per-core valid bits at once, sets sparc_decode_on to 1, no clearing pass
`default_nettype none

module delay_slot_branch_outcome_resolver
    import dsbor_pkg::*;
#(
    parameter int CORES = DSBOR_CORES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // core, pc, opcode, given_type, given_annul, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // kind
    input  wire logic                  s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // core_out, feedback_valid, feedback_pc, feedback_type, feedback_taken,
    // feedback_target, predict_valid, predict_pc, zero pad
    output logic [M_TDATA_W-1:0]       m_tdata,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int IDX_W = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int EXT_W = CORE_W + IDX_W;

    logic          sparc_decode_on_reg;

    item_t         in_item;
    logic [EXT_W-1:0] in_core_ext;
    logic [IDX_W-1:0] in_idx;
    logic          in_range;
    logic          accept;

    logic          s1_valid_reg;
    logic          s1_kind_reg;
    item_t         s1_item_reg;
    row_t          s1_row_reg;
    logic          s1_row_valid_reg;
    logic [EXT_W-1:0] s1_core_ext;
    logic [IDX_W-1:0] s1_idx;
    logic          s1_in_range;
    logic          s1_fire;
    logic          s1_write;
    logic          forward;

    row_t          mem [CORES];
    logic [CORES-1:0] row_valid_reg;

    decode_t       dec;
    row_t          cur_row;
    row_t          row_next;
    logic [PC_W-1:0] fall;
    logic          taken;
    result_t       result_next;

    logic          out_valid_reg;
    result_t       out_data_reg;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sparc_decode_on_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_SPARC_DECODE_ON))
        begin
            sparc_decode_on_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SPARC_DECODE_ON)
        begin
            prdata[0] = sparc_decode_on_reg;
        end
    end

    // input side
    assign in_item     = item_t'(s_tdata);
    assign in_core_ext = {{IDX_W{1'b0}}, in_item.core};
    assign in_idx      = in_core_ext[IDX_W-1:0];
    assign in_range    = in_core_ext < EXT_W'(CORES);

    assign s1_core_ext = {{IDX_W{1'b0}}, s1_item_reg.core};
    assign s1_idx      = s1_core_ext[IDX_W-1:0];
    assign s1_in_range = s1_core_ext < EXT_W'(CORES);

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign accept   = s_tvalid && s_tready;
    assign s1_write = s1_fire && s1_in_range;
    assign forward  = s1_write && (s1_item_reg.core == in_item.core);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= s_tuser;
            s1_item_reg <= in_item;
            if (forward)
            begin
                s1_row_reg       <= row_next;
                s1_row_valid_reg <= 1'b1;
            end
            else
            begin
                s1_row_reg       <= mem[in_idx];
                s1_row_valid_reg <= in_range ? row_valid_reg[in_idx] : 1'b0;
            end
        end
    end

    // per-core history
    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            mem[s1_idx] <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (s1_write)
        begin
            row_valid_reg[s1_idx] <= 1'b1;
        end
    end

    dsbor_decode u_decode (
        .kind        (s1_kind_reg),
        .decode_on   (sparc_decode_on_reg),
        .opcode      (s1_item_reg.opcode),
        .given_type  (s1_item_reg.given_type),
        .given_annul (s1_item_reg.given_annul),
        .dec         (dec)
    );

    // resolution
    always_comb
    begin
        cur_row = s1_row_valid_reg ? s1_row_reg : '0;
        fall    = cur_row.older.addr + FALL_OFFSET;
        taken   = 1'b1;
        if (cur_row.older.btype == BR_COND)
        begin
            taken = cur_row.older.annul ? (cur_row.newer.addr != fall)
                                        : (s1_item_reg.pc != fall);
        end

        row_next.older       = cur_row.newer;
        row_next.newer.btype = dec.btype;
        row_next.newer.annul = dec.annul;
        row_next.newer.addr  = s1_item_reg.pc;

        result_next          = '0;
        result_next.core_out = s1_item_reg.core;
        if (s1_in_range)
        begin
            if (cur_row.older.btype != BR_NONE)
            begin
                result_next.feedback_valid  = 1'b1;
                result_next.feedback_pc     = cur_row.older.addr;
                result_next.feedback_type   = cur_row.older.btype;
                result_next.feedback_taken  = taken;
                result_next.feedback_target = taken ? s1_item_reg.pc : '0;
            end
            if (dec.btype != BR_NONE)
            begin
                result_next.predict_valid = 1'b1;
                result_next.predict_pc    = s1_item_reg.pc;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are stalled");

    a_forward_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && forward) |=> s1_row_valid_reg)
        else $error("forwarded history row not marked valid");

    a_target_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.feedback_taken) |->
        (out_data_reg.feedback_target == '0))
        else $error("target present on a not-taken result");

    a_predict_pc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.predict_valid) |->
        (out_data_reg.predict_pc == '0))
        else $error("predict_pc set without a prediction request");
`endif

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench
    import dsbor_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 125;
    localparam int REPORT_MAX    = 10;

    localparam logic KIND_RAW   = 1'b0;
    localparam logic KIND_GIVEN = 1'b1;

    localparam logic [1:0] OP_MEM         = 2'd3;
    localparam logic [1:0] GTYPE_RESERVED = 2'd3;

    localparam logic [APB_ADDR_W-1:0] ADDR_SPARC_DECODE_ON = {REG_SPARC_DECODE_ON, 2'b00};

    typedef struct packed {
        logic  kind;
        item_t payload;
    } instr_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    delay_slot_branch_outcome_resolver uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic            decode_on;
    logic            slot_sel   [DSBOR_CORES];
    br_type_t        hist_type  [DSBOR_CORES][2];
    logic            hist_annul [DSBOR_CORES][2];
    logic [PC_W-1:0] hist_addr  [DSBOR_CORES][2];

    // stimulus-side pc history per core
    logic [PC_W-1:0] last_pc  [DSBOR_CORES];
    logic [PC_W-1:0] prior_pc [DSBOR_CORES];

    instr_t  trace_queue[$];
    result_t outcome_queue[$];

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned unexpected_count = 0;
    int unsigned sent_count = 0;
    int unsigned checked_count = 0;
    int unsigned taken_count = 0;
    int unsigned not_taken_count = 0;
    int unsigned predict_count = 0;

    function automatic result_t resolve_branch(input logic kind, input item_t it);
        result_t         r;
        logic            nw;
        logic            od;
        logic            taken;
        logic [PC_W-1:0] fall;
        br_type_t        t;
        logic            a;
        logic [2:0]      op2;
        r = '0;
        r.core_out = it.core;
        nw = slot_sel[it.core];
        od = ~nw;
        if (hist_type[it.core][od] != BR_NONE)
        begin
            taken = 1'b1;
            fall = hist_addr[it.core][od] + FALL_OFFSET;
            if (hist_type[it.core][od] == BR_COND)
                taken = hist_annul[it.core][od] ? (hist_addr[it.core][nw] != fall)
                                                : (it.pc != fall);
            r.feedback_valid  = 1'b1;
            r.feedback_pc     = hist_addr[it.core][od];
            r.feedback_type   = hist_type[it.core][od];
            r.feedback_taken  = taken;
            r.feedback_target = taken ? it.pc : '0;
        end
        slot_sel[it.core] = od;

        t = BR_NONE;
        a = 1'b0;
        if (kind == KIND_GIVEN)
        begin
            t = (it.given_type == GTYPE_RESERVED) ? BR_NONE : br_type_t'(it.given_type);
            a = it.given_annul;
        end
        else if (decode_on)
        begin
            op2 = it.opcode[24:22];
            case (it.opcode[31:30])
                OP_BRANCH:
                begin
                    if (op2 == OP2_BPCC || op2 == OP2_BICC || op2 == OP2_BPR ||
                        op2 == OP2_FBPFCC || op2 == OP2_FBFCC)
                    begin
                        t = BR_COND;
                        a = it.opcode[ANNUL_BIT];
                    end
                end
                OP_CALL:
                    t = BR_UNCOND;
                OP_ARITH:
                begin
                    if (it.opcode[24:19] == OP3_JMPL || it.opcode[24:19] == OP3_RETURN)
                        t = BR_UNCOND;
                end
                default:
                    t = BR_NONE;
            endcase
        end
        hist_type[it.core][od]  = t;
        hist_annul[it.core][od] = a;
        hist_addr[it.core][od]  = it.pc;

        if (t != BR_NONE)
        begin
            r.predict_valid = 1'b1;
            r.predict_pc    = it.pc;
        end
        return r;
    endfunction

    function automatic void queue_instr(input logic kind, input logic [CORE_W-1:0] core,
                                        input logic [PC_W-1:0] pc,
                                        input logic [OPCODE_W-1:0] op,
                                        input logic [1:0] gtype, input logic gannul);
        instr_t x;
        x.kind                = kind;
        x.payload.pad         = 1'b0;
        x.payload.given_annul = gannul;
        x.payload.given_type  = gtype;
        x.payload.opcode      = op;
        x.payload.pc          = pc;
        x.payload.core        = core;
        trace_queue.push_back(x);
        prior_pc[core] = last_pc[core];
        last_pc[core]  = pc;
    endfunction

    // driver
    always @(posedge clk)
    begin : drive_proc
        instr_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                outcome_queue.push_back(resolve_branch(s_tuser, item_t'(s_tdata)));
                sent_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (trace_queue.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = trace_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.payload;
                    s_tuser  <= nxt.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor_proc
        result_t got;
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (outcome_queue.size() == 0)
                begin
                    unexpected_count++;
                    if (mismatch_count + unexpected_count <= REPORT_MAX)
                        $display("unexpected transaction: core %0d fb %b pc %h pr %b %h",
                                 got.core_out, got.feedback_valid, got.feedback_pc,
                                 got.predict_valid, got.predict_pc);
                end
                else
                begin
                    want = outcome_queue.pop_front();
                    checked_count++;
                    if (want.feedback_valid)
                    begin
                        if (want.feedback_taken)
                            taken_count++;
                        else
                            not_taken_count++;
                    end
                    if (want.predict_valid)
                        predict_count++;
                    if (got.core_out !== want.core_out ||
                        got.feedback_valid !== want.feedback_valid ||
                        got.feedback_pc !== want.feedback_pc ||
                        got.feedback_type !== want.feedback_type ||
                        got.feedback_taken !== want.feedback_taken ||
                        got.feedback_target !== want.feedback_target ||
                        got.predict_valid !== want.predict_valid ||
                        got.predict_pc !== want.predict_pc)
                    begin
                        mismatch_count++;
                        if (mismatch_count + unexpected_count <= REPORT_MAX)
                        begin
                            $display("mismatch exp: core %0d fb %b %h type %0d taken %b tgt %h pr %b %h",
                                     want.core_out, want.feedback_valid, want.feedback_pc,
                                     want.feedback_type, want.feedback_taken,
                                     want.feedback_target, want.predict_valid, want.predict_pc);
                            $display("         got: core %0d fb %b %h type %0d taken %b tgt %h pr %b %h",
                                     got.core_out, got.feedback_valid, got.feedback_pc,
                                     got.feedback_type, got.feedback_taken,
                                     got.feedback_target, got.predict_valid, got.predict_pc);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned     i;
        int unsigned     ph;
        int unsigned     n;
        int unsigned     sel;
        logic [3:0]      c;
        logic [PC_W-1:0] pc;
        logic [31:0]     op;
        logic            kind_bit;
        logic            dec_val;

        decode_on = 1'b1;
        for (i = 0; i < DSBOR_CORES; i++)
        begin
            slot_sel[i]      = 1'b0;
            hist_type[i][0]  = BR_NONE;
            hist_type[i][1]  = BR_NONE;
            hist_annul[i][0] = 1'b0;
            hist_annul[i][1] = 1'b0;
            hist_addr[i][0]  = '0;
            hist_addr[i][1]  = '0;
            last_pc[i]       = '0;
            prior_pc[i]      = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: bicc not taken, call taken, annulled branch not taken, jmpl/return taken
        queue_instr(KIND_RAW, 4'd0, 64'h1000, {OP_BRANCH, 5'b00000, OP2_BICC, 22'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'h1004, {OP_BRANCH, 5'b0, OP2_SETHI, 22'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'h1008, {OP_CALL, 30'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'h100c, {OP_BRANCH, 5'b0, OP2_ILLTRAP, 22'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'h5000, {OP_BRANCH, 5'b10000, OP2_FBFCC, 22'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'h5008, {OP_ARITH, 5'b0, OP3_JMPL, 19'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'h5010, {OP_ARITH, 5'b0, OP3_RETURN, 19'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'h9000, {OP_BRANCH, 5'b10000, OP2_BPCC, 22'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'h9004, {OP_BRANCH, 5'b0, OP2_RSVD, 22'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'ha000, {OP_BRANCH, 5'b0, OP2_BPR, 22'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'ha004, {OP_BRANCH, 5'b0, OP2_FBPFCC, 22'h0}, 2'd0, 1'b0);
        queue_instr(KIND_RAW, 4'd0, 64'ha008, {OP_MEM, 30'h0}, 2'd0, 1'b0);
        // predecoded types, reserved type, annul on unconditional
        queue_instr(KIND_GIVEN, 4'd15, 64'h2000, 32'h0, BR_COND, 1'b1);
        queue_instr(KIND_GIVEN, 4'd15, 64'h2008, 32'hffff_ffff, GTYPE_RESERVED, 1'b1);
        queue_instr(KIND_GIVEN, 4'd15, 64'h200c, 32'h0, BR_UNCOND, 1'b1);
        queue_instr(KIND_GIVEN, 4'd15, 64'h2010, 32'h0, BR_NONE, 1'b0);
        queue_instr(KIND_GIVEN, 4'd15, 64'h3000, 32'h0, BR_NONE, 1'b1);
        // fall-through address wraps past the top of the address space
        queue_instr(KIND_GIVEN, 4'd15, 64'hffff_ffff_ffff_fffc, 32'h0, BR_COND, 1'b0);
        queue_instr(KIND_GIVEN, 4'd15, 64'h0, 32'h0, BR_NONE, 1'b0);
        queue_instr(KIND_GIVEN, 4'd15, 64'h4, 32'h0, BR_UNCOND, 1'b0);
        queue_instr(KIND_RAW, 4'd15, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 2'd3, 1'b1);
        queue_instr(KIND_RAW, 4'd15, 64'h0, 32'h0, 2'd0, 1'b0);

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            do
                @(negedge clk);
            while (trace_queue.size() != 0 || s_tvalid || outcome_queue.size() != 0);
            repeat (4) @(posedge clk);

            dec_val = ((ph % 3) != 1);
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_SPARC_DECODE_ON;
            pwdata  <= {{(APB_DATA_W-1){1'b0}}, dec_val};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            decode_on = dec_val;

            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                c = ($urandom_range(99) < 75) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
                sel = $urandom_range(99);
                if (sel < 45)
                    pc = last_pc[c] + 64'd4;
                else if (sel < 60)
                    pc = prior_pc[c] + FALL_OFFSET;
                else if (sel < 70)
                    pc = last_pc[c] + FALL_OFFSET;
                else if (sel < 88)
                    pc = {$urandom, $urandom} & ~64'h3;
                else if (sel < 94)
                    pc = 64'hffff_ffff_ffff_fff0 + 64'($urandom_range(3) * 4);
                else
                    pc = {$urandom, $urandom};

                op = $urandom;
                sel = $urandom_range(9);
                if (sel < 4)
                    op[31:30] = OP_BRANCH;
                else if (sel == 4)
                    op[31:30] = OP_CALL;
                else if (sel == 5)
                begin
                    op[31:30] = OP_ARITH;
                    op[24:19] = $urandom_range(1) ? OP3_JMPL : OP3_RETURN;
                end
                else if (sel == 6)
                    op[31:30] = OP_ARITH;

                kind_bit = ($urandom_range(99) < 60) ? KIND_RAW : KIND_GIVEN;
                queue_instr(kind_bit, c, pc, op, 2'($urandom_range(3)), 1'($urandom_range(1)));
            end
        end

        do
            @(negedge clk);
        while (trace_queue.size() != 0 || s_tvalid || outcome_queue.size() != 0);
        repeat (8) @(posedge clk);

        $display("%0d instructions sent over %0d traffic phases, %0d results checked",
                 sent_count, RANDOM_PHASES + 1, checked_count);
        $display("resolved %0d taken and %0d not-taken branches, %0d prediction requests",
                 taken_count, not_taken_count, predict_count);
        if (mismatch_count == 0 && unexpected_count == 0 && outcome_queue.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d unexpected, %0d missing",
                     mismatch_count, unexpected_count, outcome_queue.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: delay_slot_branch_outcome_resolver.f
hw/rtl/dsbor_pkg.sv
hw/rtl/dsbor_decode.sv
hw/rtl/delay_slot_branch_outcome_resolver.sv
verif/testbench.sv
